>>> src/opp_pkg.sv
// Shared constants, types and the arctangent table of the oval path point generator.
package opp_pkg;

  // Number of CORDIC rotation stages, one register stage each.
  localparam int CORDIC_STAGES = 16;
  localparam int ATAN_LEN      = 24;

  localparam int CFG_W     = 20;
  localparam int CFG_IDX_W = 3;

  localparam logic [16:0] ONE_Q16  = 17'd65536;
  localparam logic [16:0] HALF_Q16 = 17'd32768;

  localparam logic signed [20:0] PI_Q16      = 21'sd205887;
  localparam logic signed [20:0] HALF_PI_Q16 = 21'sd102944;
  localparam logic signed [20:0] TWO_PI_Q16  = 21'sd411775;

  localparam logic signed [31:0] GAIN_Q30      = 32'sh26DD3B6A;
  localparam logic signed [31:0] ANG_LIMIT_Q30 = 32'sd1686634496;

  localparam logic signed [19:0] POS_MIN = -20'sd98304;
  localparam logic signed [19:0] POS_MAX = 20'sd98303;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SEMI_AXIS_X       = 3'd0,
    CFG_SEMI_AXIS_Y       = 3'd1,
    CFG_CENTER_X          = 3'd2,
    CFG_CENTER_Y          = 3'd3,
    CFG_SWEEP_ANGLE       = 3'd4,
    CFG_ANTICLOCKWISE     = 3'd5,
    CFG_DEPTH_FIRST_HALF  = 3'd6,
    CFG_DEPTH_SECOND_HALF = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic        [15:0] semi_axis_x;
    logic        [15:0] semi_axis_y;
    logic signed [15:0] center_x;
    logic signed [15:0] center_y;
    logic signed [19:0] sweep_angle;
    logic               anticlockwise;
    logic signed [7:0]  depth_first_half;
    logic signed [7:0]  depth_second_half;
  } cfg_t;

  // Reduced angle entering the CORDIC, with the half-turn flag and the depth select.
  typedef struct packed {
    logic signed [31:0] ang;
    logic               flip;
    logic               half;
  } rot_t;

  // CORDIC result before the half-turn correction.
  typedef struct packed {
    logic signed [31:0] cos_q30;
    logic signed [31:0] sin_q30;
    logic               flip;
    logic               half;
  } trig_t;

  function automatic logic signed [31:0] atan_q30(input int unsigned idx);
    logic signed [31:0] val;
    case (idx)
      0:       val = 32'sh3243F6A8;
      1:       val = 32'sh1DAC6705;
      2:       val = 32'sh0FADBAFC;
      3:       val = 32'sh07F56EA6;
      4:       val = 32'sh03FEAB76;
      5:       val = 32'sh01FFD55B;
      6:       val = 32'sh00FFFAAA;
      7:       val = 32'sh007FFF55;
      8:       val = 32'sh003FFFEA;
      9:       val = 32'sh001FFFFD;
      10:      val = 32'sh000FFFFF;
      11:      val = 32'sh0007FFFF;
      12:      val = 32'sh0003FFFF;
      13:      val = 32'sh0001FFFF;
      14:      val = 32'sh0000FFFF;
      15:      val = 32'sh00007FFF;
      16:      val = 32'sh00003FFF;
      17:      val = 32'sh00001FFF;
      18:      val = 32'sh00000FFF;
      19:      val = 32'sh000007FF;
      20:      val = 32'sh000003FF;
      21:      val = 32'sh000001FF;
      22:      val = 32'sh000000FF;
      23:      val = 32'sh0000007F;
      default: val = 32'sh00000000;
    endcase
    return val;
  endfunction

endpackage

>>> src/opp_in_if.sv
// Input channel interface carrying one progress value per transaction.
interface opp_in_if;
  logic        valid;
  logic        ready;
  logic [16:0] progress;

  modport source (output valid, output progress, input ready);
  modport sink (input valid, input progress, output ready);
endinterface

>>> src/opp_out_if.sv
// Result channel interface carrying one ellipse point per transaction.
interface opp_out_if;
  logic               valid;
  logic               ready;
  logic signed [17:0] pos_x;
  logic signed [17:0] pos_y;
  logic signed [7:0]  depth_order;

  modport source (output valid, output pos_x, output pos_y, output depth_order, input ready);
  modport sink (input valid, input pos_x, input pos_y, input depth_order, output ready);
endinterface

>>> src/opp_phase.sv
// Front pipeline: progress to phase, wrap into one turn and fold into the CORDIC range.
module opp_phase (
  input  logic             clk,
  input  logic             rst_n,
  input  opp_pkg::cfg_t    cfg,
  input  logic             up_valid,
  output logic             up_ready,
  input  logic [16:0]      progress,
  output logic             dn_valid,
  input  logic             dn_ready,
  output opp_pkg::rot_t    dn_rot
);

  logic               en1, en2, en3;
  logic               v1_r, v2_r, v3_r;
  logic [16:0]        t_c, f;
  logic signed [37:0] prod, prod1_r, rnd;
  logic               half1_r, half2_r;
  logic signed [20:0] ph, ph_wrap, ph2_r, ph_fold;
  logic               flip;
  opp_pkg::rot_t      rot3_r, rot_nxt;

  assign en3      = !v3_r || dn_ready;
  assign en2      = !v2_r || en3;
  assign en1      = !v1_r || en2;
  assign up_ready = en1;

  // Stage 1: clamp progress and scale the sweep by it, or by one minus it when not anticlockwise.
  assign t_c  = (progress > opp_pkg::ONE_Q16) ? opp_pkg::ONE_Q16 : progress;
  assign f    = cfg.anticlockwise ? t_c : opp_pkg::ONE_Q16 - t_c;
  assign prod = 38'($signed(cfg.sweep_angle)) * 38'($signed({1'b0, f}));

  // Stage 2: round to Q16 and wrap into [-pi, pi].
  assign rnd = prod1_r + 38'sd32768;
  assign ph  = $signed(rnd[36:16]);

  always_comb begin
    ph_wrap = ph;
    if (ph > opp_pkg::PI_Q16) begin
      ph_wrap = ph - opp_pkg::TWO_PI_Q16;
    end else if (ph < -opp_pkg::PI_Q16) begin
      ph_wrap = ph + opp_pkg::TWO_PI_Q16;
    end
  end

  // Stage 3: fold into [-pi/2, pi/2]; the half turn is undone by negating sin and cos.
  always_comb begin
    ph_fold = ph2_r;
    flip    = 1'b0;
    if (ph2_r > opp_pkg::HALF_PI_Q16) begin
      ph_fold = ph2_r - opp_pkg::PI_Q16;
      flip    = 1'b1;
    end else if (ph2_r < -opp_pkg::HALF_PI_Q16) begin
      ph_fold = ph2_r + opp_pkg::PI_Q16;
      flip    = 1'b1;
    end
    rot_nxt.ang  = $signed({ph_fold[17:0], 14'd0});
    rot_nxt.flip = flip;
    rot_nxt.half = half2_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (en1) begin
        v1_r <= up_valid;
      end
      if (en2) begin
        v2_r <= v1_r;
      end
      if (en3) begin
        v3_r <= v2_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en1 && up_valid) begin
      prod1_r <= prod;
      half1_r <= (t_c <= opp_pkg::HALF_Q16);
    end
    if (en2 && v1_r) begin
      ph2_r   <= ph_wrap;
      half2_r <= half1_r;
    end
    if (en3 && v2_r) begin
      rot3_r <= rot_nxt;
    end
  end

  assign dn_valid = v3_r;
  assign dn_rot   = rot3_r;

`ifndef SYNTHESIS
  a_ang_range: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r |-> (rot3_r.ang <= opp_pkg::ANG_LIMIT_Q30) && (rot3_r.ang >= -opp_pkg::ANG_LIMIT_Q30))
    else $error("folded angle outside the CORDIC range");
  a_take: assert property (@(posedge clk) disable iff (!rst_n)
    up_valid && up_ready |=> v1_r)
    else $error("accepted transaction did not enter the first stage");
`endif

endmodule

>>> src/opp_cordic.sv
// Rotation-mode CORDIC, one register stage per iteration.
module opp_cordic (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             up_valid,
  output logic             up_ready,
  input  opp_pkg::rot_t    up_rot,
  output logic             dn_valid,
  input  logic             dn_ready,
  output opp_pkg::trig_t   dn_trig
);

  localparam int N = opp_pkg::CORDIC_STAGES;

  logic [N:0]         en;
  logic [N-1:0]       v_r, v_in;
  logic [N-1:0]       flip_r, half_r, flip_in, half_in;
  logic signed [31:0] x_r [N];
  logic signed [31:0] y_r [N];
  logic signed [31:0] a_r [N];
  logic signed [31:0] x_in [N];
  logic signed [31:0] y_in [N];
  logic signed [31:0] a_in [N];
  logic signed [31:0] x_nxt [N];
  logic signed [31:0] y_nxt [N];
  logic signed [31:0] a_nxt [N];

  assign en[N] = dn_ready;

  for (genvar i = 0; i < N; i++) begin : g_stage
    if (i == 0) begin : g_first
      assign v_in[i]    = up_valid;
      assign x_in[i]    = opp_pkg::GAIN_Q30;
      assign y_in[i]    = '0;
      assign a_in[i]    = up_rot.ang;
      assign flip_in[i] = up_rot.flip;
      assign half_in[i] = up_rot.half;
    end else begin : g_next
      assign v_in[i]    = v_r[i-1];
      assign x_in[i]    = x_r[i-1];
      assign y_in[i]    = y_r[i-1];
      assign a_in[i]    = a_r[i-1];
      assign flip_in[i] = flip_r[i-1];
      assign half_in[i] = half_r[i-1];
    end

    if (i < opp_pkg::ATAN_LEN) begin : g_rot
      assign x_nxt[i] = (a_in[i] >= 0) ? x_in[i] - (y_in[i] >>> i) : x_in[i] + (y_in[i] >>> i);
      assign y_nxt[i] = (a_in[i] >= 0) ? y_in[i] + (x_in[i] >>> i) : y_in[i] - (x_in[i] >>> i);
      assign a_nxt[i] = (a_in[i] >= 0) ? a_in[i] - opp_pkg::atan_q30(i)
                                       : a_in[i] + opp_pkg::atan_q30(i);
    end else begin : g_pass
      // Iterations past the table leave the vector alone.
      assign x_nxt[i] = x_in[i];
      assign y_nxt[i] = y_in[i];
      assign a_nxt[i] = a_in[i];
    end

    assign en[i] = !v_r[i] || en[i+1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int k = 0; k < N; k++) begin
        if (en[k]) begin
          v_r[k] <= v_in[k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < N; k++) begin
      if (en[k] && v_in[k]) begin
        x_r[k]    <= x_nxt[k];
        y_r[k]    <= y_nxt[k];
        a_r[k]    <= a_nxt[k];
        flip_r[k] <= flip_in[k];
        half_r[k] <= half_in[k];
      end
    end
  end

  assign up_ready        = en[0];
  assign dn_valid        = v_r[N-1];
  assign dn_trig.cos_q30 = x_r[N-1];
  assign dn_trig.sin_q30 = y_r[N-1];
  assign dn_trig.flip    = flip_r[N-1];
  assign dn_trig.half    = half_r[N-1];

`ifndef SYNTHESIS
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !up_ready |-> (&v_r))
    else $error("CORDIC refused a transaction while a stage was empty");
`endif

endmodule

>>> src/opp_scale.sv
// Back pipeline: half-turn correction, axis scaling, rounding, centering, saturation and depth select.
module opp_scale (
  input  logic               clk,
  input  logic               rst_n,
  input  opp_pkg::cfg_t      cfg,
  input  logic               up_valid,
  output logic               up_ready,
  input  opp_pkg::trig_t     up_trig,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [17:0] pos_x,
  output logic signed [17:0] pos_y,
  output logic signed [7:0]  depth_order
);

  logic               en1, en2, en3, en4;
  logic               v1_r, v2_r, v3_r, v4_r;
  logic signed [31:0] c1_r, s1_r;
  logic               half1_r, half2_r, half3_r;
  logic signed [48:0] px, py, px2_r, py2_r, rx, ry;
  logic signed [18:0] rx3_r, ry3_r;
  logic signed [19:0] sx, sy;
  logic signed [17:0] pos_x_r, pos_y_r, sat_x, sat_y;
  logic signed [7:0]  depth_r;

  assign en4      = !v4_r || out_ready;
  assign en3      = !v3_r || en4;
  assign en2      = !v2_r || en3;
  assign en1      = !v1_r || en2;
  assign up_ready = en1;

  assign px = 49'($signed({1'b0, cfg.semi_axis_x})) * 49'(c1_r);
  assign py = 49'($signed({1'b0, cfg.semi_axis_y})) * 49'(s1_r);

  // Round half up out of Q30.
  assign rx = px2_r + 49'sd536870912;
  assign ry = py2_r + 49'sd536870912;

  assign sx = 20'(rx3_r) + 20'(cfg.center_x);
  assign sy = 20'(ry3_r) + 20'(cfg.center_y);

  always_comb begin
    if (sx < opp_pkg::POS_MIN) begin
      sat_x = opp_pkg::POS_MIN[17:0];
    end else if (sx > opp_pkg::POS_MAX) begin
      sat_x = opp_pkg::POS_MAX[17:0];
    end else begin
      sat_x = sx[17:0];
    end
    if (sy < opp_pkg::POS_MIN) begin
      sat_y = opp_pkg::POS_MIN[17:0];
    end else if (sy > opp_pkg::POS_MAX) begin
      sat_y = opp_pkg::POS_MAX[17:0];
    end else begin
      sat_y = sy[17:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (en1) begin
        v1_r <= up_valid;
      end
      if (en2) begin
        v2_r <= v1_r;
      end
      if (en3) begin
        v3_r <= v2_r;
      end
      if (en4) begin
        v4_r <= v3_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en1 && up_valid) begin
      c1_r    <= up_trig.flip ? -up_trig.cos_q30 : up_trig.cos_q30;
      s1_r    <= up_trig.flip ? -up_trig.sin_q30 : up_trig.sin_q30;
      half1_r <= up_trig.half;
    end
    if (en2 && v1_r) begin
      px2_r   <= px;
      py2_r   <= py;
      half2_r <= half1_r;
    end
    if (en3 && v2_r) begin
      rx3_r   <= $signed(rx[48:30]);
      ry3_r   <= $signed(ry[48:30]);
      half3_r <= half2_r;
    end
    if (en4 && v3_r) begin
      pos_x_r <= sat_x;
      pos_y_r <= sat_y;
      depth_r <= half3_r ? cfg.depth_first_half : cfg.depth_second_half;
    end
  end

  assign out_valid   = v4_r;
  assign pos_x       = pos_x_r;
  assign pos_y       = pos_y_r;
  assign depth_order = depth_r;

`ifndef SYNTHESIS
  a_open_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !v4_r |-> up_ready)
    else $error("back pipeline stalled with an empty output register");
`endif

endmodule

>>> src/oval_path_point_core.sv
// Pipeline: 3 phase stages, 16 CORDIC stages and 4 scaling stages between an accepted
// transaction and its result; the CORDIC depth follows the stage count in the package.
// Throughput: one transaction per cycle while the output accepts results; every stage holds
// its own valid bit and a stage only waits when the stage after it is full and stalled.
// Reset: synchronous, active low; clears all valid bits and sets every configuration
// register to zero.
module oval_path_point_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wen,
  input  logic [opp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [opp_pkg::CFG_W-1:0]     cfg_wdata,
  opp_in_if.sink                        in_ch,
  opp_out_if.source                     out_ch
);

  opp_pkg::cfg_t  cfg_r;
  logic           ph_valid, ph_ready, cd_valid, cd_ready;
  opp_pkg::rot_t  ph_rot;
  opp_pkg::trig_t cd_trig;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_wen) begin
      case (opp_pkg::cfg_idx_t'(cfg_index))
        opp_pkg::CFG_SEMI_AXIS_X:       cfg_r.semi_axis_x       <= cfg_wdata[15:0];
        opp_pkg::CFG_SEMI_AXIS_Y:       cfg_r.semi_axis_y       <= cfg_wdata[15:0];
        opp_pkg::CFG_CENTER_X:          cfg_r.center_x          <= $signed(cfg_wdata[15:0]);
        opp_pkg::CFG_CENTER_Y:          cfg_r.center_y          <= $signed(cfg_wdata[15:0]);
        opp_pkg::CFG_SWEEP_ANGLE:       cfg_r.sweep_angle       <= $signed(cfg_wdata[19:0]);
        opp_pkg::CFG_ANTICLOCKWISE:     cfg_r.anticlockwise     <= cfg_wdata[0];
        opp_pkg::CFG_DEPTH_FIRST_HALF:  cfg_r.depth_first_half  <= $signed(cfg_wdata[7:0]);
        opp_pkg::CFG_DEPTH_SECOND_HALF: cfg_r.depth_second_half <= $signed(cfg_wdata[7:0]);
        default: begin
        end
      endcase
    end
  end

  opp_phase u_phase (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .up_valid (in_ch.valid),
    .up_ready (in_ch.ready),
    .progress (in_ch.progress),
    .dn_valid (ph_valid),
    .dn_ready (ph_ready),
    .dn_rot   (ph_rot)
  );

  opp_cordic u_cordic (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (ph_valid),
    .up_ready (ph_ready),
    .up_rot   (ph_rot),
    .dn_valid (cd_valid),
    .dn_ready (cd_ready),
    .dn_trig  (cd_trig)
  );

  opp_scale u_scale (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .up_valid    (cd_valid),
    .up_ready    (cd_ready),
    .up_trig     (cd_trig),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .pos_x       (out_ch.pos_x),
    .pos_y       (out_ch.pos_y),
    .depth_order (out_ch.depth_order)
  );

endmodule
